[hdl/wws_pkg.sv]
// Shared types and constants for the waveform window statistics block.
package wws_pkg;

    localparam int WINDOW_MAX  = 4096;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 13;
    localparam int SUM_W       = 29;
    localparam int SUMSQ_W     = 43;
    localparam int PROD_W      = 56;
    localparam int DIVISOR_W   = 26;
    localparam int VAR_W       = 31;

    localparam logic [15:0] CLIP_LIMIT_RST = 16'h8000;
    localparam logic        KIND_CLIP      = 1'b0;
    localparam logic        KIND_STATS     = 1'b1;
    localparam logic        REG_CLIP_LIMIT = 1'b0;

    // One queue entry: an optional clip event and an optional window snapshot
    typedef struct packed {
        logic                       has_clip;
        logic [31:0]                clip_time;
        logic                       clip_last;
        logic                       has_stats;
        logic [COUNT_W-1:0]         n;
        logic signed [SUM_W-1:0]    sum;
        logic [SUMSQ_W-1:0]         sumsq;
        logic [15:0]                p2p;
        logic [COUNT_W-1:0]         clips;
        logic                       dropped;
    } t_cmd;

    typedef struct packed {
        logic                       kind;
        logic [31:0]                clip_time;
        logic [15:0]                rms;
        logic [15:0]                p2p;
        logic signed [15:0]         mean;
        logic [VAR_W-1:0]           variance;
        logic [COUNT_W-1:0]         clip_count;
        logic [COUNT_W-1:0]         sample_count;
        logic                       overflow;
        logic                       last_result;
    } t_res;

endpackage

[hdl/wws_div.sv]
// Restoring divider, one quotient bit per cycle.
module wws_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wws_pkg::PROD_W-1:0]     i_dividend,
    input  logic [wws_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [wws_pkg::PROD_W-1:0]     o_quotient
);
    import wws_pkg::*;

    logic                 r_busy;
    logic [5:0]           r_cnt;
    logic [DIVISOR_W:0]   r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIVISOR_W-1:0] r_dvs;
    logic                 r_done;
    logic [DIVISOR_W:0]   w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem[DIVISOR_W-1:0], r_quo[PROD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    // Shift in one dividend bit, subtract where the divisor fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(PROD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? (w_trial - {1'b0, r_dvs}) : w_trial;
                r_quo <= {r_quo[PROD_W-2:0], w_fit};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/wws_queue.sv]
// Two-entry command queue between the accumulator front and the result back.
module wws_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wws_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wws_pkg::t_cmd o_cmd
);
    import wws_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Advance pointers and count on push and pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

endmodule

[hdl/wws_front.sv]
// Sample front end: window accumulators, clip detection and command issue.
module wws_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_sample,
    input  logic [31:0]           i_timestamp,
    input  logic                  i_last,
    input  logic [15:0]           i_clip_limit,
    input  logic                  i_full,
    output logic                  o_push,
    output wws_pkg::t_cmd         o_cmd
);
    import wws_pkg::*;

    logic [COUNT_W-1:0]      r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [SUMSQ_W-1:0]      r_sumsq;
    logic signed [15:0]      r_max;
    logic signed [15:0]      r_min;
    logic [COUNT_W-1:0]      r_clips;
    logic                    r_drop;

    logic                    w_acc;
    logic                    w_room;
    logic signed [16:0]      w_sext;
    logic [16:0]             w_mag;
    logic [33:0]             w_sq;
    logic                    w_clip;
    logic [COUNT_W-1:0]      n_count;
    logic signed [SUM_W-1:0] n_sum;
    logic [SUMSQ_W-1:0]      n_sumsq;
    logic signed [15:0]      n_max;
    logic signed [15:0]      n_min;
    logic [COUNT_W-1:0]      n_clips;
    logic                    n_drop;
    logic signed [16:0]      w_span;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_room  = r_count < COUNT_W'(WINDOW_MAX);
    assign w_sext  = 17'(i_sample);
    assign w_mag   = i_sample[15] ? 17'(-w_sext) : 17'(w_sext);
    assign w_sq    = w_mag * w_mag;
    assign w_clip  = w_room && (w_mag >= {1'b0, i_clip_limit});

    // Window state after this sample
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_max   = r_max;
        n_min   = r_min;
        n_clips = r_clips;
        n_drop  = r_drop;
        if (w_room) begin
            n_count = r_count + COUNT_W'(1);
            n_sum   = r_sum + SUM_W'(i_sample);
            n_sumsq = r_sumsq + SUMSQ_W'(w_sq);
            n_max   = (r_count == '0 || i_sample > r_max) ? i_sample : r_max;
            n_min   = (r_count == '0 || i_sample < r_min) ? i_sample : r_min;
            n_clips = r_clips + COUNT_W'(w_clip);
        end else begin
            n_drop = 1'b1;
        end
    end

    assign w_span = 17'(n_max) - 17'(n_min);

    // Build the command for the back end
    always_comb begin
        o_cmd.has_clip  = w_clip;
        o_cmd.clip_time = i_timestamp;
        o_cmd.clip_last = !i_last;
        o_cmd.has_stats = i_last;
        o_cmd.n         = n_count;
        o_cmd.sum       = n_sum;
        o_cmd.sumsq     = n_sumsq;
        o_cmd.p2p       = w_span[15:0];
        o_cmd.clips     = n_clips;
        o_cmd.dropped   = n_drop;
    end

    assign o_push = w_acc && (w_clip || i_last);

    // Hold accumulators, clear at the end of a window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_clips <= '0;
            r_drop  <= 1'b0;
        end else if (w_acc) begin
            if (i_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_max   <= '0;
                r_min   <= '0;
                r_clips <= '0;
                r_drop  <= 1'b0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sumsq <= n_sumsq;
                r_max   <= n_max;
                r_min   <= n_min;
                r_clips <= n_clips;
                r_drop  <= n_drop;
            end
        end
    end

endmodule

[hdl/wws_back.sv]
// Result back end: clip events, window division, square root and output register.
module wws_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  wws_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output wws_pkg::t_res o_res
);
    import wws_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLIP, ST_MUL, ST_SQ_GO, ST_SQ_WAIT, ST_ROOT,
        ST_MEAN_GO, ST_MEAN_WAIT, ST_VAR_GO, ST_VAR_WAIT, ST_STAT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    t_res                  r_res;
    logic                  r_valid;
    logic [PROD_W-1:0]     r_p1;
    logic [PROD_W-1:0]     r_p2;
    logic [DIVISOR_W-1:0]  r_nn;
    logic [PROD_W-1:0]     r_dvd;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic                  r_start;
    logic [30:0]           r_x;
    logic [31:0]           r_root;
    logic [31:0]           r_bit;
    logic signed [15:0]    r_mean;
    logic [VAR_W-1:0]      r_var;

    logic                  w_free;
    logic                  w_emit;
    logic [27:0]           w_sabs;
    logic                  w_done;
    logic [PROD_W-1:0]     w_quo;
    logic [31:0]           w_try;
    logic [15:0]           w_mq;
    logic                  w_nz;

    wws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_done),
        .o_quotient (w_quo)
    );

    assign w_free = !r_valid || i_ready;
    assign w_emit = (r_state inside {ST_CLIP, ST_STAT}) && w_free;
    assign w_sabs = r_cmd.sum[SUM_W-1] ? 28'(-r_cmd.sum) : 28'(r_cmd.sum);
    assign w_try  = r_root + r_bit;
    assign w_mq   = w_quo[15:0];
    assign w_nz   = r_cmd.n != '0;
    assign o_pop  = (r_state == ST_IDLE) && !i_empty;

    // Sequence one command through clip output and window arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_valid <= w_emit || (r_valid && !i_ready);
            r_start <= r_state inside {ST_SQ_GO, ST_MEAN_GO, ST_VAR_GO};
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= i_cmd.has_clip ? ST_CLIP : ST_MUL;
                    end
                end
                ST_CLIP: begin
                    if (w_free) begin
                        r_res   <= '{kind: KIND_CLIP, clip_time: r_cmd.clip_time,
                                     rms: '0, p2p: '0, mean: '0, variance: '0,
                                     clip_count: '0, sample_count: '0, overflow: 1'b0,
                                     last_result: r_cmd.clip_last};
                        r_state <= r_cmd.has_stats ? ST_MUL : ST_IDLE;
                    end
                end
                ST_MUL: begin
                    r_p1    <= PROD_W'(r_cmd.n) * PROD_W'(r_cmd.sumsq);
                    r_p2    <= PROD_W'(w_sabs) * PROD_W'(w_sabs);
                    r_nn    <= DIVISOR_W'(r_cmd.n) * DIVISOR_W'(r_cmd.n);
                    r_state <= ST_SQ_GO;
                end
                ST_SQ_GO: begin
                    r_dvd   <= PROD_W'(r_cmd.sumsq);
                    r_dvs   <= DIVISOR_W'(r_cmd.n);
                    r_state <= ST_SQ_WAIT;
                end
                ST_SQ_WAIT: begin
                    if (w_done) begin
                        r_x     <= w_quo[30:0];
                        r_root  <= '0;
                        r_bit   <= 32'h4000_0000;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (32'(r_x) >= w_try) begin
                        r_x    <= 31'(32'(r_x) - w_try);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 32'd1) begin
                        r_state <= ST_MEAN_GO;
                    end
                end
                ST_MEAN_GO: begin
                    r_dvd   <= PROD_W'(w_sabs);
                    r_dvs   <= DIVISOR_W'(r_cmd.n);
                    r_state <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT: begin
                    if (w_done) begin
                        r_mean  <= r_cmd.sum[SUM_W-1] ? -w_mq : w_mq;
                        r_state <= ST_VAR_GO;
                    end
                end
                ST_VAR_GO: begin
                    r_dvd   <= r_p1 - r_p2;
                    r_dvs   <= r_nn;
                    r_state <= ST_VAR_WAIT;
                end
                ST_VAR_WAIT: begin
                    if (w_done) begin
                        r_var   <= w_quo[VAR_W-1:0];
                        r_state <= ST_STAT;
                    end
                end
                ST_STAT: begin
                    if (w_free) begin
                        r_res.kind         <= KIND_STATS;
                        r_res.clip_time    <= '0;
                        r_res.rms          <= w_nz ? r_root[15:0] : '0;
                        r_res.p2p          <= w_nz ? r_cmd.p2p : '0;
                        r_res.mean         <= w_nz ? r_mean : '0;
                        r_res.variance     <= w_nz ? r_var : '0;
                        r_res.clip_count   <= r_cmd.clips;
                        r_res.sample_count <= r_cmd.n;
                        r_res.overflow     <= r_cmd.dropped;
                        r_res.last_result  <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hdl/waveform_window_statistics_top.sv]
// Path: a clip event passes through the command queue, the back end's command register
// and its output register; window results take three divisions on one shared divider
// plus a 16-step root, queued behind any earlier commands.
// Throughput: one sample per cycle while the two-entry command queue has room;
// a window end occupies the back end for its three divisions and the root.
// Reset: synchronous active-low; clears accumulators, queue, back end, clip limit 32768.
module waveform_window_statistics_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Sample stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [47:0]   i_s_tdata,   // [15:0] sample, [47:16] timestamp
    input  logic          i_s_tlast,   // last sample of window
    // Result stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [143:0]  o_m_tdata,   // [31:0] clip_time, [47:32] rms,
                                       // [63:48] peak_to_peak, [79:64] mean,
                                       // [110:80] variance, [123:111] clip_count,
                                       // [136:124] sample_count, [137] overflow
    output logic          o_m_tuser,   // kind
    output logic          o_m_tlast,   // last_result
    // Register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import wws_pkg::*;

    logic [15:0] r_clip_limit;
    logic        w_full;
    logic        w_empty;
    logic        w_push;
    logic        w_pop;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;
    t_res        w_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLIP_LIMIT) ? {16'd0, r_clip_limit} : 32'd0;

    // Write the clip limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_limit <= CLIP_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_CLIP_LIMIT) begin
            r_clip_limit <= pwdata[15:0];
        end
    end

    wws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_sample     (i_s_tdata[15:0]),
        .i_timestamp  (i_s_tdata[47:16]),
        .i_last       (i_s_tlast),
        .i_clip_limit (r_clip_limit),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd_in)
    );

    wws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    wws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_cmd_out),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res)
    );

    // Pack the result transaction
    assign o_m_tdata = {6'd0, w_res.overflow, w_res.sample_count, w_res.clip_count,
                        w_res.variance, w_res.mean, w_res.p2p, w_res.rms,
                        w_res.clip_time};
    assign o_m_tuser = w_res.kind;
    assign o_m_tlast = w_res.last_result;

endmodule

[test/tb_waveform_window_statistics_top.sv]
// Self-checking testbench for the waveform window statistics block.
module tb_waveform_window_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wws_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [47:0]   i_s_tdata = '0;
    logic          i_s_tlast = 1'b0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [143:0]  o_m_tdata;
    logic          o_m_tuser;
    logic          o_m_tlast;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    waveform_window_statistics_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [15:0]          clip_threshold;
    int unsigned          window_count;
    longint               window_sum;
    longint unsigned      window_sqsum;
    longint               window_max;
    longint               window_min;
    int unsigned          window_clips;
    bit                   window_dropped;
    t_res                 pending_results[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_request = 0;
    int  hold_cnt = 0;
    int  errors = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic void clear_window();
        window_count = 0;
        window_sum = 0;
        window_sqsum = 0;
        window_max = 0;
        window_min = 0;
        window_clips = 0;
        window_dropped = 0;
    endfunction

    // Advance the window state for one accepted sample and queue its results
    function automatic void predict_sample(logic signed [15:0] smp, logic [31:0] ts,
                                           logic lst);
        longint          s;
        longint unsigned mag;
        longint unsigned n;
        longint unsigned sabs;
        t_res            r;
        s = smp;
        mag = (s < 0) ? -s : s;
        if (window_count < WINDOW_MAX) begin
            if (window_count == 0) begin
                window_max = s;
                window_min = s;
            end else begin
                if (s > window_max) window_max = s;
                if (s < window_min) window_min = s;
            end
            window_count++;
            window_sum += s;
            window_sqsum += mag * mag;
            if (mag >= clip_threshold) begin
                window_clips++;
                r = '0;
                r.kind = KIND_CLIP;
                r.clip_time = ts;
                r.last_result = !lst;
                pending_results.push_back(r);
            end
        end else begin
            window_dropped = 1;
        end
        if (lst) begin
            r = '0;
            n = window_count;
            if (n != 0) begin
                sabs = (window_sum < 0) ? -window_sum : window_sum;
                r.rms = floor_sqrt(window_sqsum / n);
                r.mean = window_sum / longint'(n);
                r.variance = (n * window_sqsum - sabs * sabs) / (n * n);
                r.p2p = window_max - window_min;
            end
            r.kind = KIND_STATS;
            r.clip_count = window_clips;
            r.sample_count = n;
            r.overflow = window_dropped;
            r.last_result = 1'b1;
            pending_results.push_back(r);
            clear_window();
        end
    endfunction

    // Offer one sample, idling at random first; return once it is accepted
    task automatic send_sample(logic signed [15:0] smp, logic [31:0] ts, logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {ts, smp};
        i_s_tlast <= lst;
        forever begin
            @(negedge i_clk);
            if (o_s_tready) break;
            @(posedge i_clk);
        end
        predict_sample(smp, ts, lst);
        @(posedge i_clk);
    endtask

    task automatic hold_valid_low();
        i_s_tvalid <= 1'b0;
    endtask

    // Wait until every expected transaction has arrived and the back end is quiet
    task automatic drain();
        hold_valid_low();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_clip_limit(logic [15:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(REG_CLIP_LIMIT) << 2;
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        clip_threshold = value;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_window(int len);
        for (int k = 1; k <= len; k++) send_sample(rand_sample(), $urandom, k == len);
    endtask

    // Extremes of sample and timestamp, single-sample windows, clip on the last sample
    task automatic test_directed();
        send_sample(16'sh8000, 32'h0000_0000, 1'b1);
        send_sample(16'sh7FFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(16'sh8000, 32'hFFFF_FFFF, 1'b0);
        send_sample(16'sh7FFF, 32'h1234_5678, 1'b0);
        send_sample(16'sh0000, 32'hA5A5_5A5A, 1'b0);
        send_sample(-16'sd1, 32'h0000_0001, 1'b0);
        send_sample(16'sh0001, 32'h8000_0000, 1'b1);
        send_sample(-16'sd7, 32'd7, 1'b0);
        send_sample(-16'sd2, 32'd8, 1'b1);
    endtask

    // Zero limit clips everything; a limit of one spares only zero; all ones never clips; 100 at its edge
    task automatic test_clip_limits();
        write_clip_limit(16'd0);
        send_window(4);
        write_clip_limit(16'd1);
        send_sample(16'sd0, 32'd1, 1'b0);
        send_sample(-16'sd1, 32'd2, 1'b0);
        send_sample(16'sd1, 32'd3, 1'b1);
        write_clip_limit(16'hFFFF);
        send_window(5);
        write_clip_limit(16'd100);
        send_sample(16'sd99, 32'd4, 1'b0);
        send_sample(-16'sd100, 32'd5, 1'b0);
        send_sample(16'sd100, 32'd6, 1'b1);
    endtask

    // Fill the window, then drop samples including one marked last, then send a short window
    task automatic test_full_window();
        write_clip_limit(16'd32000);
        for (int k = 0; k < WINDOW_MAX + 3; k++)
            send_sample((k % 2) ? 16'sh8000 : 16'sh7FFF, $urandom, k == WINDOW_MAX + 2);
        send_window(3);
    endtask

    // Random windows under each idling mode, with a long receiver hold-off in the last mode
    task automatic test_random();
        int sent;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 69 : 0;
            recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 37 : 0;
            write_clip_limit(mode == 2 ? 16'h8000 : 16'($urandom_range(1, 32768)));
            sent = 0;
            if (mode == 2) hold_request = 600;
            while (sent < 316) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
                send_window(len);
                sent += len;
            end
        end
    endtask

    // Receiver ready, with random idling and a counted hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_cnt = hold_request;
            hold_request = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(negedge i_clk) begin
        t_res e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("kind", e.kind, o_m_tuser);
                check_field("clip_time", e.clip_time, o_m_tdata[31:0]);
                check_field("rms", e.rms, o_m_tdata[47:32]);
                check_field("peak_to_peak", e.p2p, o_m_tdata[63:48]);
                check_field("mean", unsigned'(e.mean), o_m_tdata[79:64]);
                check_field("variance", e.variance, o_m_tdata[110:80]);
                check_field("clip_count", e.clip_count, o_m_tdata[123:111]);
                check_field("sample_count", e.sample_count, o_m_tdata[136:124]);
                check_field("overflow", e.overflow, o_m_tdata[137]);
                check_field("last_result", e.last_result, o_m_tlast);
            end
        end
    end

    initial begin
        clip_threshold = CLIP_LIMIT_RST;
        clear_window();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        recv_idle_pct = 20;
        test_directed();
        test_clip_limits();
        test_full_window();
        test_random();
        drain();
        if (pending_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
